// ----- rtl/gcne_pkg.sv -----
package gcne_pkg;

  localparam int MAX_AXIS_CELLS = 16;
  localparam int CFG_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int IDX_W          = 12;
  localparam int AXIS_W         = $clog2(MAX_AXIS_CELLS + 1);
  localparam int POS_W          = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1;
  localparam int PLANE_W        = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS + 1);
  localparam int DIV_STEPS      = IDX_W / 2;
  localparam int DCNT_W         = $clog2(DIV_STEPS);
  localparam int NUM_DIRS       = 26;
  localparam int DIR_W          = $clog2(NUM_DIRS);

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  typedef struct packed {
    logic [AXIS_W-1:0]  len;
    logic [AXIS_W-1:0]  wid;
    logic [AXIS_W-1:0]  hgt;
    logic [PLANE_W-1:0] plane;
  } geom_t;

  typedef struct packed {
    logic [IDX_W-1:0]    base;
    logic [NUM_DIRS-1:0] mask;
    logic                err;
  } entry_t;

  // visit order: in-plane ring, layer above, layer below
  localparam logic [1:0] DIR_DX [NUM_DIRS] = '{
    STEP_ZERO, STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS, STEP_NEG, STEP_NEG, STEP_POS,
    STEP_ZERO, STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS,
    STEP_NEG,
    STEP_ZERO, STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS,
    STEP_NEG
  };

  localparam logic [1:0] DIR_DY [NUM_DIRS] = '{
    STEP_POS, STEP_POS, STEP_POS, STEP_NEG, STEP_NEG, STEP_NEG, STEP_ZERO, STEP_ZERO,
    STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_POS, STEP_POS, STEP_POS, STEP_NEG, STEP_NEG,
    STEP_NEG,
    STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_POS, STEP_POS, STEP_POS, STEP_NEG, STEP_NEG,
    STEP_NEG
  };

  localparam logic [1:0] DIR_DZ [NUM_DIRS] = '{
    STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO, STEP_ZERO,
    STEP_ZERO,
    STEP_POS, STEP_POS, STEP_POS, STEP_POS, STEP_POS, STEP_POS, STEP_POS, STEP_POS,
    STEP_POS,
    STEP_NEG, STEP_NEG, STEP_NEG, STEP_NEG, STEP_NEG, STEP_NEG, STEP_NEG, STEP_NEG,
    STEP_NEG
  };

  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [CFG_W-1:0] v);
    logic [AXIS_W-1:0] r;
    if (v == '0) begin
      r = AXIS_W'(1);
    end else if (32'(v) > MAX_AXIS_CELLS) begin
      r = AXIS_W'(MAX_AXIS_CELLS);
    end else begin
      r = AXIS_W'(v);
    end
    return r;
  endfunction

  function automatic logic axis_ok(input logic [POS_W-1:0] pos, input logic [1:0] d,
                                   input logic [AXIS_W-1:0] size);
    logic ok;
    case (d)
      STEP_NEG: ok = (pos != '0);
      STEP_POS: ok = ({1'b0, AXIS_W'(pos)} + (AXIS_W+1)'(1)) < {1'b0, size};
      default:  ok = 1'b1;
    endcase
    return ok;
  endfunction

  // one restoring divide step: {remainder, quotient bit}
  function automatic logic [AXIS_W:0] div_step(input logic [AXIS_W-1:0] rem,
                                               input logic b,
                                               input logic [AXIS_W-1:0] d);
    logic [AXIS_W:0] t;
    logic [AXIS_W:0] r;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      r = {AXIS_W'(t - {1'b0, d}), 1'b1};
    end else begin
      r = {AXIS_W'(t), 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/gcne_front.sv -----
module gcne_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [11:0]         in_cell_index,
  input  gcne_pkg::geom_t     geom,
  input  logic                q_full,
  output logic                q_push,
  output gcne_pkg::entry_t    q_entry
);
  import gcne_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV1, S_DIV2, S_PUSH} state_t;

  state_t              state_r, state_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    dvd_r, dvd_nxt;
  logic [AXIS_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]    base_r, base_nxt;
  logic [POS_W-1:0]    col_r, col_nxt;
  logic [POS_W-1:0]    row_r, row_nxt;

  logic [AXIS_W-1:0]   divisor;
  logic [AXIS_W:0]     st1, st2;
  logic                accept;
  logic                last_step;
  logic [POS_W-1:0]    lay;
  logic                err;
  logic [NUM_DIRS-1:0] mask;

  assign in_stall  = !((state_r == S_IDLE) || (state_r == S_PUSH && !q_full));
  assign accept    = in_valid && !in_stall;
  assign q_push    = (state_r == S_PUSH) && !q_full;
  assign divisor   = (state_r == S_DIV1) ? geom.len : geom.wid;
  assign st1       = div_step(rem_r, dvd_r[IDX_W-1], divisor);
  assign st2       = div_step(st1[AXIS_W:1], dvd_r[IDX_W-2], divisor);
  assign last_step = (cnt_r == DCNT_W'(DIV_STEPS - 1));

  // after the second pass dvd_r holds index div plane, i.e. the layer
  assign lay = dvd_r[POS_W-1:0];
  assign err = (dvd_r >= IDX_W'(geom.hgt));

  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      mask[k] = !err && axis_ok(col_r, DIR_DX[k], geom.len) &&
                axis_ok(row_r, DIR_DY[k], geom.wid) &&
                axis_ok(lay, DIR_DZ[k], geom.hgt);
    end
  end

  assign q_entry = '{base: base_r, mask: mask, err: err};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    base_nxt  = base_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DIV1, S_DIV2: begin
        dvd_nxt = {dvd_r[IDX_W-3:0], st1[0], st2[0]};
        rem_nxt = st2[AXIS_W:1];
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (last_step) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          if (state_r == S_DIV1) begin
            col_nxt   = st2[POS_W:1];
            state_nxt = S_DIV2;
          end else begin
            row_nxt   = st2[POS_W:1];
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (accept) begin
      dvd_nxt   = in_cell_index;
      base_nxt  = in_cell_index;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = S_DIV1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
  end

endmodule

// ----- rtl/gcne_fifo.sv -----
module gcne_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gcne_pkg::entry_t push_data,
  input  logic             pop,
  output gcne_pkg::entry_t pop_data,
  output logic             full,
  output logic             empty
);
  import gcne_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/gcne_back.sv -----
module gcne_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gcne_pkg::geom_t    geom,
  input  logic               q_empty,
  input  gcne_pkg::entry_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_neighbor_index,
  output logic signed [1:0]  out_step_x,
  output logic signed [1:0]  out_step_y,
  output logic signed [1:0]  out_step_z,
  output logic               out_last_of_run,
  output logic               out_index_error
);
  import gcne_pkg::*;

  logic                act_r, act_nxt;
  logic [IDX_W-1:0]    base_r, base_nxt;
  logic [NUM_DIRS-1:0] mask_r, mask_nxt;
  logic                err_r, err_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    nidx_r, nidx_nxt;
  logic [1:0]          sx_r, sx_nxt;
  logic [1:0]          sy_r, sy_nxt;
  logic [1:0]          sz_r, sz_nxt;
  logic                last_r, last_nxt;
  logic                ierr_r, ierr_nxt;

  logic                out_free;
  logic                emit;
  logic                done;
  logic                can_load;
  logic [NUM_DIRS-1:0] rest;
  logic [DIR_W-1:0]    k;
  logic [1:0]          dx, dy, dz;
  logic [IDX_W-1:0]    len_x, plane_x;
  logic [IDX_W-1:0]    x_term, y_term, z_term;
  logic [IDX_W-1:0]    nbr;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = act_r && out_free;
  assign rest     = mask_r & (mask_r - NUM_DIRS'(1));
  assign done     = err_r || (rest == '0);
  assign can_load = !act_r || (emit && done);
  assign q_pop    = can_load && !q_empty;

  // lowest pending direction
  always_comb begin
    k = '0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        k = DIR_W'(i);
      end
    end
  end

  assign dx      = DIR_DX[k];
  assign dy      = DIR_DY[k];
  assign dz      = DIR_DZ[k];
  assign len_x   = IDX_W'(geom.len);
  assign plane_x = IDX_W'(geom.plane);
  assign x_term  = {{(IDX_W-1){dx[1]}}, dx[0]};

  always_comb begin
    case (dy)
      STEP_POS: y_term = len_x;
      STEP_NEG: y_term = -len_x;
      default:  y_term = '0;
    endcase
    case (dz)
      STEP_POS: z_term = plane_x;
      STEP_NEG: z_term = -plane_x;
      default:  z_term = '0;
    endcase
  end

  assign nbr = base_r + x_term + y_term + z_term;

  always_comb begin
    act_nxt       = act_r;
    base_nxt      = base_r;
    mask_nxt      = mask_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    nidx_nxt      = nidx_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    last_nxt      = last_r;
    ierr_nxt      = ierr_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      mask_nxt      = rest;
      act_nxt       = !done;
      last_nxt      = done;
      ierr_nxt      = err_r;
      if (err_r) begin
        nidx_nxt = '0;
        sx_nxt   = STEP_ZERO;
        sy_nxt   = STEP_ZERO;
        sz_nxt   = STEP_ZERO;
      end else begin
        nidx_nxt = nbr;
        sx_nxt   = dx;
        sy_nxt   = dy;
        sz_nxt   = dz;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    // a request with no neighbours is dropped here
    if (q_pop) begin
      base_nxt = q_data.base;
      mask_nxt = q_data.mask;
      err_nxt  = q_data.err;
      act_nxt  = q_data.err || (q_data.mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r <= base_nxt;
    mask_r <= mask_nxt;
    err_r  <= err_nxt;
    nidx_r <= nidx_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sz_r   <= sz_nxt;
    last_r <= last_nxt;
    ierr_r <= ierr_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_index = nidx_r;
  assign out_step_x         = sx_r;
  assign out_step_y         = sy_r;
  assign out_step_z         = sz_r;
  assign out_last_of_run    = last_r;
  assign out_index_error    = ierr_r;

endmodule

// ----- rtl/grid_cell_neighbor_enumerator_core.sv -----
// channel   direction  handshake          payload
// in        input      in_valid/in_stall   in_cell_index
// out       output     out_valid/out_stall out_neighbor_index, out_step_*, out_last_of_run,
//                                          out_index_error
// cfg       input      cfg_wr_en           cfg_index, cfg_wdata
//
// the front splits each index with a radix-4 divider in two passes
// (column, then row and layer), and takes a new request only once the last is queued.
// the back sends one result per cycle while not stalled: up to 26 for an interior cell,
// one for an out-of-grid index, none for a single-cell grid.
// reset sets all axis sizes to 1 and empties the two-entry queue; no clearing pass.
// out_stall holds the result register and stops the back; in_stall rises while
// the divider is busy or a split request waits on a full queue.
module grid_cell_neighbor_enumerator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [11:0]       in_cell_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       out_neighbor_index,
  output logic signed [1:0] out_step_x,
  output logic signed [1:0] out_step_y,
  output logic signed [1:0] out_step_z,
  output logic              out_last_of_run,
  output logic              out_index_error,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_wdata
);
  import gcne_pkg::*;

  logic [CFG_W-1:0]   length_r, width_r, height_r;
  logic [PLANE_W-1:0] plane_r;
  geom_t              geom;
  logic               q_push, q_pop, q_full, q_empty;
  entry_t             q_entry, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= CFG_W'(1);
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LENGTH: length_r <= cfg_wdata;
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // plane is only needed by the back, long after the divider has started
  always_ff @(posedge clk) begin
    plane_r <= PLANE_W'(clamp_axis(length_r)) * PLANE_W'(clamp_axis(width_r));
  end

  assign geom = '{len: clamp_axis(length_r), wid: clamp_axis(width_r),
                  hgt: clamp_axis(height_r), plane: plane_r};

  gcne_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_index (in_cell_index),
    .geom          (geom),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  gcne_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  gcne_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .geom               (geom),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_index (out_neighbor_index),
    .out_step_x         (out_step_x),
    .out_step_y         (out_step_y),
    .out_step_z         (out_step_z),
    .out_last_of_run    (out_last_of_run),
    .out_index_error    (out_index_error)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |-> (out_last_of_run && out_neighbor_index == '0 &&
      out_step_x == '0 && out_step_y == '0 && out_step_z == '0))
    else $error("error result not a lone zero result");

  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_x != 2'b10 && out_step_y != 2'b10 && out_step_z != 2'b10))
    else $error("illegal step code");

endmodule
